// ===== rtl/wwls_pkg.sv =====
`default_nettype none

package wwls_pkg;

    // Sizing defaults for the top level.
    localparam int WW_MAX_LINE    = 63;
    localparam int WW_QUEUE_DEPTH = 2;

    // Character codes.
    localparam logic [7:0] NL_CHAR   = 8'd10;
    localparam logic [7:0] ZERO_CHAR = 8'd0;

    // Register reset values.
    localparam logic [5:0] LEN_RESET  = 6'd32;
    localparam logic [7:0] SEP_RESET  = 8'd32;
    localparam logic       KEEP_RESET = 1'b0;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Input request kinds.
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Result kinds.
    localparam logic OUT_CHAR = 1'b0;
    localparam logic OUT_DONE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LINE_LENGTH = 2'd0,
        CFG_SEPARATOR   = 2'd1,
        CFG_KEEP_SEP    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [5:0] line_length;
        logic [7:0] separator_char;
        logic       keep_separator;
    } t_cfg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_char;
        logic [31:0] lines_added;
        logic        last_of_run;
    } t_out_item;

    // Commands passed from the front end to the line engine.
    typedef enum logic [1:0] {
        CMD_CHAR    = 2'd0,
        CMD_NEWLINE = 2'd1,
        CMD_END     = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] ch;
    } t_cmd_item;

    // Line engine states.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_EMIT   = 2'd2
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/wwls_front.sv =====
`default_nettype none

module wwls_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire wwls_pkg::t_in_item   i_in_data,
    input  wire                       i_q_full,
    output logic                      o_push,
    output wwls_pkg::t_cmd_item       o_push_item
);
    import wwls_pkg::*;

    logic      r_valid;
    t_cmd_item r_item;
    t_cmd_item n_item;
    logic      accept;
    logic      keep;
    logic      drain;

    // The staging register drains into the queue whenever the queue has room.
    assign drain      = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push      = drain;
    assign o_push_item = r_item;

    // Classify the arriving item; zero characters are dropped here.
    always_comb begin
        n_item.ch = i_in_data.char_in;
        keep      = 1'b1;
        if (i_in_data.req_type == REQ_END) begin
            n_item.cmd = CMD_END;
        end else if (i_in_data.char_in == NL_CHAR) begin
            n_item.cmd = CMD_NEWLINE;
        end else begin
            n_item.cmd = CMD_CHAR;
            keep       = (i_in_data.char_in != ZERO_CHAR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept && keep) begin
            r_valid <= 1'b1;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wwls_queue.sv =====
`default_nettype none

module wwls_queue #(
    parameter int DEPTH = wwls_pkg::WW_QUEUE_DEPTH
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  wire wwls_pkg::t_cmd_item  i_push_item,
    output logic                      o_full,
    input  wire                       i_pop,
    output logic                      o_valid,
    output wwls_pkg::t_cmd_item       o_item
);
    import wwls_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd_item     r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers wrap at the last slot; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wwls_engine.sv =====
`default_nettype none

module wwls_engine #(
    parameter int MAX_LINE = wwls_pkg::WW_MAX_LINE
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire wwls_pkg::t_cfg       i_cfg,
    input  wire                       i_q_valid,
    input  wire wwls_pkg::t_cmd_item  i_q_item,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output wwls_pkg::t_out_item       o_out_data
);
    import wwls_pkg::*;

    // Ring buffer address width, ring depth and pending-count width.
    localparam int AW = $clog2(MAX_LINE + 1);
    localparam int RD = 2 ** AW;
    localparam int FW = $clog2(MAX_LINE + 2);
    localparam logic [5:0]    MAX6    = 6'(MAX_LINE);
    localparam logic [AW-1:0] POS_ONE = AW'(1);

    // Line buffer as a ring; the pending line starts at r_head.
    logic [7:0]    r_mem [RD];
    logic [7:0]    r_mem_q;

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [31:0]   r_count;

    // Separator search.
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_chk_pos;
    logic          r_chk_valid;

    // Emission.
    logic [FW-1:0] r_left;
    logic [FW-1:0] r_start;
    logic [AW-1:0] r_rd_ptr;
    logic          r_final_done;
    logic          r_dv;

    logic          r_out_valid;
    t_out_item     r_out;

    // Control signals.
    logic [AW-1:0] len;
    logic [FW-1:0] n_fill;
    logic          out_free;
    logic          mem_we;
    logic          do_append;
    logic          do_break;
    logic          sep_zero;
    logic          found;
    logic          hard;
    logic          rd_search;
    logic          rd_emit;
    logic          load_data;
    logic          load_final;
    logic          set_emit;
    logic [FW-1:0] emit_len;
    logic [FW-1:0] emit_start;
    logic          emit_done;
    logic [AW-1:0] rd_addr;

    // Effective line length clamped into 1..MAX_LINE.
    always_comb begin
        if (i_cfg.line_length == 6'd0) begin
            len = POS_ONE;
        end else if (i_cfg.line_length > MAX6) begin
            len = AW'(MAX_LINE);
        end else begin
            len = AW'(i_cfg.line_length);
        end
    end

    assign n_fill   = r_fill + 1'b1;
    assign sep_zero = (i_cfg.separator_char == ZERO_CHAR);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_addr  = rd_search ? (r_head + r_pos) : r_rd_ptr;

    // Datapath control for each state.
    always_comb begin
        o_q_pop    = 1'b0;
        mem_we     = 1'b0;
        do_append  = 1'b0;
        do_break   = 1'b0;
        found      = 1'b0;
        hard       = 1'b0;
        rd_search  = 1'b0;
        rd_emit    = 1'b0;
        load_data  = 1'b0;
        load_final = 1'b0;
        set_emit   = 1'b0;
        emit_len   = r_fill;
        emit_start = r_fill;
        emit_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.cmd)
                        CMD_CHAR: begin
                            mem_we = 1'b1;
                            if (n_fill > FW'(len)) begin
                                do_break = 1'b1;
                                // With no separator the break is hard at once.
                                set_emit   = sep_zero;
                                emit_len   = FW'(len);
                                emit_start = FW'(len);
                            end else begin
                                do_append = 1'b1;
                            end
                        end
                        CMD_NEWLINE: begin
                            set_emit = 1'b1;
                        end
                        CMD_END: begin
                            set_emit  = 1'b1;
                            emit_done = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // Scan backward from position len, one buffer read per cycle.
                if (r_chk_valid && (r_mem_q == i_cfg.separator_char)) begin
                    found      = 1'b1;
                    set_emit   = 1'b1;
                    emit_len   = FW'(r_chk_pos);
                    emit_start = i_cfg.keep_separator ? FW'(r_chk_pos)
                                                      : FW'(r_chk_pos) + 1'b1;
                end else if (r_chk_valid && (r_chk_pos == POS_ONE)) begin
                    hard       = 1'b1;
                    set_emit   = 1'b1;
                    emit_len   = FW'(len);
                    emit_start = FW'(len);
                end else begin
                    rd_search = (r_pos != '0);
                end
            end
            ST_EMIT: begin
                load_data  = r_dv && out_free;
                rd_emit    = (r_left != '0) && (!r_dv || out_free);
                load_final = (r_left == '0) && !r_dv && out_free;
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (do_break && !sep_zero) begin
                    n_state = ST_SEARCH;
                end else if (set_emit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_SEARCH: begin
                if (found || hard) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_final) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_chk_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= rd_search;
            if (do_append || do_break) begin
                r_fill <= n_fill;
            end
            if (do_break && (r_count != COUNT_MAX)) begin
                r_count <= r_count + 1'b1;
            end
            if (rd_emit) begin
                r_dv <= 1'b1;
            end else if (load_data) begin
                r_dv <= 1'b0;
            end
            // The last result retires the consumed characters.
            if (load_final) begin
                r_head <= r_head + AW'(r_start);
                r_fill <= r_fill - r_start;
                if (r_final_done) begin
                    r_count <= '0;
                end
            end
            if (load_data || load_final) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Search and emission payload registers.
    always_ff @(posedge i_clk) begin
        if (do_break) begin
            r_pos <= len;
        end else if (rd_search) begin
            r_pos <= r_pos - 1'b1;
        end
        r_chk_pos <= r_pos;
        if (set_emit) begin
            r_left       <= emit_len;
            r_start      <= emit_start;
            r_rd_ptr     <= r_head;
            r_final_done <= emit_done;
        end else if (rd_emit) begin
            r_left   <= r_left - 1'b1;
            r_rd_ptr <= r_rd_ptr + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load_data) begin
            r_out.out_kind    <= OUT_CHAR;
            r_out.out_char    <= r_mem_q;
            r_out.lines_added <= r_count;
            r_out.last_of_run <= 1'b0;
        end else if (load_final) begin
            r_out.out_kind    <= r_final_done ? OUT_DONE : OUT_CHAR;
            r_out.out_char    <= r_final_done ? ZERO_CHAR : NL_CHAR;
            r_out.lines_added <= r_count;
            r_out.last_of_run <= 1'b1;
        end
    end

    // Line buffer memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_head + AW'(r_fill)] <= i_q_item.ch;
        end
        if (rd_search || rd_emit) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/word_wrap_line_splitter_top.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall o_out_data (t_out_item)
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_wdata
//
// An appended character passes the front register and the queue, then is written to the line buffer.
// A break runs a backward separator search (none for a zero separator) and then emits the
// characters of the line and the newline; a newline or end item emits the pending characters
// and a newline or done result. Output stalls hold the emission.
// Synchronous active-low reset restores control state and register defaults; the line buffer
// needs no clearing pass. A short command queue lets input transfers continue during output.

module word_wrap_line_splitter_top #(
    parameter int MAX_LINE    = wwls_pkg::WW_MAX_LINE,
    parameter int QUEUE_DEPTH = wwls_pkg::WW_QUEUE_DEPTH
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire wwls_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output wwls_pkg::t_out_item       o_out_data,
    input  wire                       i_cfg_we,
    input  wire [1:0]                 i_cfg_idx,
    input  wire [7:0]                 i_cfg_wdata
);
    import wwls_pkg::*;

    t_cfg      r_cfg;
    logic      push;
    t_cmd_item push_item;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    t_cmd_item q_item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_length    <= LEN_RESET;
            r_cfg.separator_char <= SEP_RESET;
            r_cfg.keep_separator <= KEEP_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LINE_LENGTH: r_cfg.line_length    <= i_cfg_wdata[5:0];
                CFG_SEPARATOR:   r_cfg.separator_char <= i_cfg_wdata;
                CFG_KEEP_SEP:    r_cfg.keep_separator <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    wwls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    wwls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_item      (q_item)
    );

    wwls_engine #(
        .MAX_LINE (MAX_LINE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/wrap_check.sv =====
`timescale 1ns / 1ps

module wrap_check
    import wwls_pkg::*;
#(
    parameter int MAX_LINE = WW_MAX_LINE
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_stall,
    input  t_in_item   i_in_data,
    input  wire        i_out_valid,
    input  wire        i_out_stall,
    input  t_out_item  i_out_data,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [7:0]  i_cfg_wdata,
    output int         o_failures,
    output int         o_pending
);

    // Shadow copy of the line state and the registers.
    logic [7:0]  line_buf [MAX_LINE];
    int          fill;
    logic [31:0] breaks;
    logic [5:0]  len_reg;
    logic [7:0]  sep_reg;
    logic        keep_reg;

    // Characters and done results still owed by the block, oldest first.
    t_out_item   wrapped_q [$];
    int          failures;

    initial begin
        o_failures = 0;
        o_pending  = 0;
        failures   = 0;
        fill       = 0;
        breaks     = '0;
        len_reg    = LEN_RESET;
        sep_reg    = SEP_RESET;
        keep_reg   = KEEP_RESET;
    end

    function automatic t_out_item char_result(input logic kind, input logic [7:0] ch);
        t_out_item r;
        r          = '0;
        r.out_kind = kind;
        r.out_char = ch;
        return r;
    endfunction

    // Work out every result that one input transfer causes and queue them.
    task automatic predict_wrap(input t_in_item it);
        logic [7:0] pend [MAX_LINE+1];
        t_out_item  run [$];
        int         n;
        int         len;
        int         p;
        int         start;
        bit         found;

        if (it.req_type == REQ_END) begin
            for (int i = 0; i < fill; i++) run.push_back(char_result(OUT_CHAR, line_buf[i]));
            fill = 0;
            run.push_back(char_result(OUT_DONE, ZERO_CHAR));
        end else if (it.char_in == NL_CHAR) begin
            for (int i = 0; i < fill; i++) run.push_back(char_result(OUT_CHAR, line_buf[i]));
            fill = 0;
            run.push_back(char_result(OUT_CHAR, NL_CHAR));
        end else if (it.char_in != ZERO_CHAR) begin
            for (int i = 0; i < fill; i++) pend[i] = line_buf[i];
            pend[fill] = it.char_in;
            n = fill + 1;
            len = (len_reg == 6'd0) ? 1 : int'(len_reg);

            if (n <= len) begin
                line_buf[fill] = it.char_in;
                fill++;
            end else begin
                // Last separator among positions 1..len, a zero separator matches nothing.
                found = 1'b0;
                p = 0;
                if (sep_reg != ZERO_CHAR) begin
                    for (int i = len; i >= 1 && !found; i--) begin
                        if (pend[i] == sep_reg) begin
                            found = 1'b1;
                            p = i;
                        end
                    end
                end
                if (found) begin
                    for (int i = 0; i < p; i++) run.push_back(char_result(OUT_CHAR, pend[i]));
                    start = keep_reg ? p : p + 1;
                end else begin
                    for (int i = 0; i < len; i++) run.push_back(char_result(OUT_CHAR, pend[i]));
                    start = len;
                end
                run.push_back(char_result(OUT_CHAR, NL_CHAR));
                if (breaks != COUNT_MAX) breaks++;

                // The remainder starts the next pending line.
                fill = 0;
                for (int i = start; i < n && fill < MAX_LINE; i++) begin
                    line_buf[fill] = pend[i];
                    fill++;
                end
            end
        end

        foreach (run[k]) begin
            run[k].lines_added = breaks;
            run[k].last_of_run = (k == run.size() - 1);
            wrapped_q.push_back(run[k]);
        end
        if (it.req_type == REQ_END) breaks = '0;
    endtask

    // Follow register writes and both channels at every edge.
    always @(posedge i_clk) begin
        t_out_item want;

        if (!i_rst_n) begin
            fill     = 0;
            breaks   = '0;
            len_reg  = LEN_RESET;
            sep_reg  = SEP_RESET;
            keep_reg = KEEP_RESET;
            wrapped_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LINE_LENGTH: len_reg  = i_cfg_wdata[5:0];
                    CFG_SEPARATOR:   sep_reg  = i_cfg_wdata;
                    CFG_KEEP_SEP:    keep_reg = i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) predict_wrap(i_in_data);

            if (i_out_valid && !i_out_stall) begin
                if (wrapped_q.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("unexpected result: kind=%0d char=%02h count=%0d last=%0d",
                                 i_out_data.out_kind, i_out_data.out_char,
                                 i_out_data.lines_added, i_out_data.last_of_run);
                    end
                end else begin
                    want = wrapped_q.pop_front();
                    if (i_out_data.out_kind !== want.out_kind ||
                        i_out_data.out_char !== want.out_char ||
                        i_out_data.lines_added !== want.lines_added ||
                        i_out_data.last_of_run !== want.last_of_run) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("mismatch: expected kind=%0d char=%02h count=%0d last=%0d",
                                     want.out_kind, want.out_char,
                                     want.lines_added, want.last_of_run);
                            $display("          got      kind=%0d char=%02h count=%0d last=%0d",
                                     i_out_data.out_kind, i_out_data.out_char,
                                     i_out_data.lines_added, i_out_data.last_of_run);
                        end
                    end
                end
            end
        end

        o_failures = failures;
        o_pending  = wrapped_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import wwls_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 200;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_item    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = CFG_LINE_LENGTH;
    logic [7:0]  cfg_wdata = '0;

    int          fail_count;
    int          pending_count;
    int          cycles     = 0;
    int          stall_hold = 0;
    logic        quiet_out  = 1'b0;
    bit          burst_in   = 1'b0;
    int          cur_len    = LEN_RESET;
    logic [7:0]  cur_sep    = SEP_RESET;

    always #5 clk = ~clk;

    word_wrap_line_splitter_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    wrap_check wrap_mon (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_failures  (fail_count),
        .o_pending   (pending_count)
    );

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Run guard.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("word_wrap_line_splitter_top test failed");
            $finish;
        end
    end

    // Receiver stalls in random runs, or not at all in a quiet stretch.
    always @(posedge clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            out_stall  <= quiet_out ? 1'b0 : 1'($urandom_range(0, 1));
            stall_hold <= pick_gap();
        end
    end

    // Hold the item until its transfer, then idle for a while unless in a burst.
    task automatic send_item(input t_in_item it);
        int gap;
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        gap = burst_in ? 0 : pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item('{REQ_CHAR, s[i]});
    endtask

    // Stop sending until every result is in, then let a silent item finish.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on back-to-back cycles.
    task automatic apply_config(input logic [7:0] len_w, input logic [7:0] sep,
                                input logic keep);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_LINE_LENGTH;
        cfg_wdata <= len_w;
        @(posedge clk);
        cfg_idx   <= CFG_SEPARATOR;
        cfg_wdata <= sep;
        @(posedge clk);
        cfg_idx   <= CFG_KEEP_SEP;
        cfg_wdata <= {7'd0, keep};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_len = (len_w[5:0] == 6'd0) ? 1 : int'(len_w[5:0]);
        cur_sep = sep;
    endtask

    // Words of random content split by the current separator, with some
    // newlines, end items and raw bytes mixed in. Zero bytes do not count.
    task automatic run_random(input int count, input int flush_pct);
        int        sent;
        int        word_left;
        int        max_word;
        int        r;
        t_in_item  it;
        sent      = 0;
        max_word  = cur_len + 2;
        word_left = $urandom_range(1, max_word);
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < flush_pct / 2) begin
                it = '{REQ_END, 8'($urandom)};
            end else if (r < flush_pct) begin
                it = '{REQ_CHAR, NL_CHAR};
            end else if (r < flush_pct + 8) begin
                it = '{REQ_CHAR, 8'($urandom)};
            end else if (word_left == 0) begin
                it = '{REQ_CHAR, cur_sep};
                word_left = $urandom_range(1, max_word);
            end else begin
                if ($urandom_range(0, 9) == 0) it = '{REQ_CHAR, 8'($urandom_range(128, 255))};
                else it = '{REQ_CHAR, 8'($urandom_range(33, 126))};
                word_left--;
            end
            send_item(it);
            if (it.req_type == REQ_END || it.char_in != ZERO_CHAR) sent++;
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a plain byte, 0xFF, an ignored zero, newline, end with junk data.
        send_item('{REQ_CHAR, 8'h78});
        send_item('{REQ_CHAR, 8'hFF});
        send_item('{REQ_CHAR, ZERO_CHAR});
        send_item('{REQ_CHAR, NL_CHAR});
        send_item('{REQ_END, 8'hA5});
        drain_results();

        // Short lines broken at spaces, separator dropped.
        apply_config(8'd4, 8'h20, 1'b0);
        send_text("ab cd ef");
        send_item('{REQ_END, ZERO_CHAR});
        drain_results();

        // No separator, then the line length drops under a pending line.
        apply_config(8'd8, ZERO_CHAR, 1'b1);
        send_text("abcdefg");
        drain_results();
        apply_config(8'd2, ZERO_CHAR, 1'b1);
        send_text("h ");
        send_item('{REQ_CHAR, NL_CHAR});
        drain_results();

        // Random phases over a spread of settings.
        for (int ph = 0; ph < 6; ph++) begin
            burst_in = ($urandom_range(0, 3) == 0);
            quiet_out <= ($urandom_range(0, 3) == 0);
            case (ph)
                0: apply_config(8'd0, 8'h20, 1'b0);
                1: apply_config(8'($urandom_range(3, 10)), ZERO_CHAR, 1'b1);
                2: apply_config(8'hFF, 8'h2D, 1'b1);
                3: apply_config(8'($urandom_range(3, 10)), NL_CHAR, 1'b0);
                4: apply_config(8'($urandom_range(2, 12)), 8'($urandom_range(1, 255)), 1'b1);
                default: apply_config(8'($urandom_range(2, 12)), 8'h20,
                                      1'($urandom_range(0, 1)));
            endcase
            if (ph == 2) run_random(40, 0);
            else run_random(14, 12);
            drain_results();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("word_wrap_line_splitter_top test passed");
        end else begin
            $display("word_wrap_line_splitter_top test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wwls_pkg.sv
rtl/wwls_front.sv
rtl/wwls_queue.sv
rtl/wwls_engine.sv
rtl/word_wrap_line_splitter_top.sv
tb/sv/wrap_check.sv
tb/sv/testbench.sv
